// File: hdl/chb_pkg.sv
// Package for the color histogram back-projection block.
// Holds sizes, request and operation codes, queue entry types and index helpers.
// Depends on nothing; every other file of the block but chb_ram uses it.
`default_nettype none

package chb_pkg;

   // Sizes of the pixel fields and of the bin store.
   localparam int LEVEL_BITS   = 8;
   localparam int CHANNEL_BITS = 6;
   localparam int BIN_BITS     = 16;
   localparam int VALUE_BITS   = 16;
   localparam int WEIGHT_BITS  = 16;
   localparam int INDEX_BITS   = 3 * CHANNEL_BITS;
   localparam int BIN_COUNT    = 1 << INDEX_BITS;

   // Depths of the work queue and of the result queue.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
   localparam logic [BIN_BITS-1:0]    BIN_MAX    = '1;

   // Request codes as they arrive on the input port.
   localparam logic [1:0] REQ_ACCUM   = 2'd0;
   localparam logic [1:0] REQ_PROJECT = 2'd1;
   localparam logic [1:0] REQ_WRITE   = 2'd2;

   // Operation carried from the front end to the back end.
   typedef enum logic [1:0] {
      OP_ACCUM   = 2'd0,
      OP_PROJECT = 2'd1,
      OP_WRITE   = 2'd2
   } op_type;

   // One classified request waiting for the back end.
   typedef struct packed {
      op_type                 op;
      logic [INDEX_BITS-1:0]  index;
      logic [BIN_BITS-1:0]    value;
      logic                   frame_end;
   } item_type;

   // One finished back-projection result.
   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight;
      logic                   frame_done;
   } result_type;

   // Bin index: top bits of red, then green, then blue.
   function automatic logic [INDEX_BITS-1:0] bin_index(
      input logic [LEVEL_BITS-1:0] red,
      input logic [LEVEL_BITS-1:0] green,
      input logic [LEVEL_BITS-1:0] blue
   );
      return {red[LEVEL_BITS-1 -: CHANNEL_BITS],
              green[LEVEL_BITS-1 -: CHANNEL_BITS],
              blue[LEVEL_BITS-1 -: CHANNEL_BITS]};
   endfunction

   // Write value fitted to the bin width (masked or zero extended).
   function automatic logic [BIN_BITS-1:0] value_to_bin(input logic [VALUE_BITS-1:0] value);
      logic [BIN_BITS+VALUE_BITS-1:0] wide;
      wide = (BIN_BITS + VALUE_BITS)'(value);
      return wide[BIN_BITS-1:0];
   endfunction

   // Bin count to output weight, saturating when bins are wider than the weight.
   function automatic logic [WEIGHT_BITS-1:0] bin_to_weight(input logic [BIN_BITS-1:0] count);
      logic [BIN_BITS+WEIGHT_BITS-1:0] wide;
      wide = (BIN_BITS + WEIGHT_BITS)'(count);
      if (wide > (BIN_BITS + WEIGHT_BITS)'(WEIGHT_MAX)) begin
         return WEIGHT_MAX;
      end
      return wide[WEIGHT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/chb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module chb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; a read of the address being written returns old data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/chb_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on chb_pkg.
`default_nettype none

module chb_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   output logic                                      full,
   input  wire logic [1:0]                           req_type,
   input  wire logic [chb_pkg::LEVEL_BITS-1:0]       req_blue_level,
   input  wire logic [chb_pkg::LEVEL_BITS-1:0]       req_green_level,
   input  wire logic [chb_pkg::LEVEL_BITS-1:0]       req_red_level,
   input  wire logic [chb_pkg::VALUE_BITS-1:0]       req_bin_value,
   input  wire logic                                 req_frame_end,
   input  wire logic                                 clear_busy,
   input  wire logic                                 q_pop,
   output logic                                      q_valid,
   output chb_pkg::item_type                         q_head
);

   import chb_pkg::*;

   item_type               entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   accepted;
   logic                   enqueue;
   logic                   dequeue;
   item_type               new_item;

   // Classify the request; the unused request code is dropped here.
   always_comb begin
      new_item.op        = OP_ACCUM;
      new_item.index     = bin_index(req_red_level, req_green_level, req_blue_level);
      new_item.value     = value_to_bin(req_bin_value);
      new_item.frame_end = req_frame_end;
      enqueue            = 1'b0;
      unique case (req_type)
         REQ_ACCUM: begin
            new_item.op = OP_ACCUM;
            enqueue     = accepted;
         end
         REQ_PROJECT: begin
            new_item.op = OP_PROJECT;
            enqueue     = accepted;
         end
         REQ_WRITE: begin
            new_item.op = OP_WRITE;
            enqueue     = accepted;
         end
         default: begin
            enqueue = 1'b0;
         end
      endcase
   end

   // Input transfer and queue bookkeeping.
   assign full     = clear_busy || (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign accepted = push && !full;
   assign q_valid  = (count_ff != '0);
   assign dequeue  = q_pop && q_valid;
   assign q_head   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enqueue) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (dequeue) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enqueue && !dequeue) begin
         count_in = count_ff + 1'b1;
      end else if (dequeue && !enqueue) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (enqueue) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

// File: hdl/chb_back.sv
// Back end: clears the bin store after reset, then runs one bin read-modify-write
// per queued request and queues back-projection results. Depends on chb_pkg, chb_ram.
`default_nettype none

module chb_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             q_valid,
   input  wire chb_pkg::item_type                q_head,
   output logic                                  q_pop,
   output logic                                  clear_busy,
   output logic                                  empty,
   input  wire logic                             pop,
   output logic [chb_pkg::WEIGHT_BITS-1:0]       rsp_weight,
   output logic                                  rsp_frame_done
);

   import chb_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   item_type               item_ff, item_in;
   logic [INDEX_BITS-1:0]  clear_addr_ff, clear_addr_in;

   logic                   wr_en;
   logic [INDEX_BITS-1:0]  wr_addr;
   logic [BIN_BITS-1:0]    wr_data;
   logic [BIN_BITS-1:0]    rd_data;

   result_type             out_entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   out_wr_ptr_ff, out_wr_ptr_in;
   logic [QPTR_BITS-1:0]   out_rd_ptr_ff, out_rd_ptr_in;
   logic [QCNT_BITS-1:0]   out_count_ff, out_count_in;
   logic                   out_push;
   logic                   out_pop;
   logic                   out_room;
   result_type             out_item;

   // Bin store; the read address follows the queue head so data is ready in EXEC.
   chb_ram #(
      .WIDTH (BIN_BITS),
      .DEPTH (BIN_COUNT)
   ) u_chb_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (q_head.index),
      .rd_data (rd_data)
   );

   assign out_room   = (out_count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign clear_busy = (state_ff == ST_CLEAR);

   // Sequencer: clearing sweep, then fetch in IDLE and update in EXEC.
   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      clear_addr_in  = clear_addr_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = item_ff.index;
      wr_data        = item_ff.value;
      out_push       = 1'b0;
      out_item.weight     = bin_to_weight(rd_data);
      out_item.frame_done = item_ff.frame_end;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            wr_data       = '0;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == INDEX_BITS'(BIN_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid && out_room) begin
               q_pop    = 1'b1;
               item_in  = q_head;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (item_ff.op)
               OP_ACCUM: begin
                  wr_en   = (rd_data != BIN_MAX);
                  wr_data = rd_data + 1'b1;
               end
               OP_PROJECT: begin
                  out_push = 1'b1;
               end
               OP_WRITE: begin
                  wr_en   = 1'b1;
                  wr_data = item_ff.value;
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // Result queue toward the output port.
   assign empty   = (out_count_ff == '0);
   assign out_pop = pop && !empty;

   always_comb begin
      out_wr_ptr_in = out_wr_ptr_ff;
      out_rd_ptr_in = out_rd_ptr_ff;
      out_count_in  = out_count_ff;
      if (out_push) begin
         out_wr_ptr_in = (out_wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                         '0 : out_wr_ptr_ff + 1'b1;
      end
      if (out_pop) begin
         out_rd_ptr_in = (out_rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                         '0 : out_rd_ptr_ff + 1'b1;
      end
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (out_pop && !out_push) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         out_wr_ptr_ff <= out_wr_ptr_in;
         out_rd_ptr_ff <= out_rd_ptr_in;
         out_count_ff  <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_entries_ff[out_wr_ptr_ff] <= out_item;
      end
   end

   assign rsp_weight     = out_entries_ff[out_rd_ptr_ff].weight;
   assign rsp_frame_done = out_entries_ff[out_rd_ptr_ff].frame_done;

endmodule

`default_nettype wire

// File: hdl/color_histogram_backproject.sv
// Color histogram back projection, top level. Depends on chb_pkg, chb_front, chb_back.
// Requests are served one at a time by the bin read-modify-write sequencer, which
// fetches the bin in IDLE and updates it in EXEC on the single-write-port bin RAM;
// it fetches only while the result queue has room and queues results in EXEC.
// Reset: synchronous; afterwards full stays high while all 262144 bins of the
// store are swept to zero, one bin per cycle.
`default_nettype none

module color_histogram_backproject (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   output logic                                  full,
   input  wire logic [1:0]                       req_type,
   input  wire logic [chb_pkg::LEVEL_BITS-1:0]   req_blue_level,
   input  wire logic [chb_pkg::LEVEL_BITS-1:0]   req_green_level,
   input  wire logic [chb_pkg::LEVEL_BITS-1:0]   req_red_level,
   input  wire logic [chb_pkg::VALUE_BITS-1:0]   req_bin_value,
   input  wire logic                             req_frame_end,
   output logic                                  empty,
   input  wire logic                             pop,
   output logic [chb_pkg::WEIGHT_BITS-1:0]       rsp_weight,
   output logic                                  rsp_frame_done
);

   import chb_pkg::*;

   item_type q_head;
   logic     q_valid;
   logic     q_pop;
   logic     clear_busy;

   // Request classification and work queue.
   chb_front u_chb_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_blue_level  (req_blue_level),
      .req_green_level (req_green_level),
      .req_red_level   (req_red_level),
      .req_bin_value   (req_bin_value),
      .req_frame_end   (req_frame_end),
      .clear_busy      (clear_busy),
      .q_pop           (q_pop),
      .q_valid         (q_valid),
      .q_head          (q_head)
   );

   // Bin updates, lookups and result queue.
   chb_back u_chb_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .clear_busy     (clear_busy),
      .empty          (empty),
      .pop            (pop),
      .rsp_weight     (rsp_weight),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire

// File: hdl/chb_checker.sv
// Port-level checker for the color histogram back projection block, with its bind.
// Depends on chb_pkg and the top level color_histogram_backproject.
`default_nettype none

module chb_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             push,
   input wire logic                             full,
   input wire logic                             empty,
   input wire logic                             pop,
   input wire logic [chb_pkg::WEIGHT_BITS-1:0]  rsp_weight,
   input wire logic                             rsp_frame_done
);

   // After reset the store is being cleared, so no request may transfer.
   assert property (@(posedge clock) reset |=> full)
      else $error("full not raised after reset");

   // Reset discards every pending result.
   assert property (@(posedge clock) reset |=> empty)
      else $error("result pending after reset");

   // A waiting result is not withdrawn.
   assert property (@(posedge clock) disable iff (reset) (!empty && !pop) |=> !empty)
      else $error("result withdrawn before transfer");

   // A waiting result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> ($stable(rsp_weight) && $stable(rsp_frame_done)))
      else $error("result changed before transfer");

endmodule

bind color_histogram_backproject chb_checker u_chb_checker (.*);

`default_nettype wire

// File: verif/chb_weight_checker.sv
`timescale 1ns / 100ps
// Checker for the color histogram back-projection block: keeps its own bin store,
// predicts the weight of every back-projection transfer and compares each result.
// Depends on chb_pkg for sizes, request codes and the result entry type.

module chb_weight_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire logic                             full,
   input  wire logic [1:0]                       req_type,
   input  wire logic [chb_pkg::LEVEL_BITS-1:0]   req_blue_level,
   input  wire logic [chb_pkg::LEVEL_BITS-1:0]   req_green_level,
   input  wire logic [chb_pkg::LEVEL_BITS-1:0]   req_red_level,
   input  wire logic [chb_pkg::VALUE_BITS-1:0]   req_bin_value,
   input  wire logic                             req_frame_end,
   input  wire logic                             empty,
   input  wire logic                             pop,
   input  wire logic [chb_pkg::WEIGHT_BITS-1:0]  rsp_weight,
   input  wire logic                             rsp_frame_done,
   output int                                    failures,
   output int                                    expected_waiting,
   output int                                    weights_checked
);

   import chb_pkg::*;

   localparam int MAX_REPORTS = 10;

   // Private copy of the bin store and the weights still owed by the block.
   logic [BIN_BITS-1:0] bin_count [BIN_COUNT];
   result_type          owed_weights [$];

   // The store starts cleared, as the block leaves it after its sweep.
   initial begin
      foreach (bin_count[i]) begin
         bin_count[i] = '0;
      end
   end

   // Bin address: upper bits of each channel, red on top and blue at the bottom.
   function automatic logic [INDEX_BITS-1:0] pixel_bin(
      input logic [LEVEL_BITS-1:0] red,
      input logic [LEVEL_BITS-1:0] green,
      input logic [LEVEL_BITS-1:0] blue
   );
      logic [INDEX_BITS-1:0] addr;
      addr = INDEX_BITS'(red >> (LEVEL_BITS - CHANNEL_BITS));
      addr = (addr << CHANNEL_BITS) | INDEX_BITS'(green >> (LEVEL_BITS - CHANNEL_BITS));
      addr = (addr << CHANNEL_BITS) | INDEX_BITS'(blue >> (LEVEL_BITS - CHANNEL_BITS));
      return addr;
   endfunction

   // A bin wider than the weight port is clipped to the largest weight.
   function automatic logic [WEIGHT_BITS-1:0] count_as_weight(input logic [BIN_BITS-1:0] count);
      longint unsigned level;
      level = longint'(count);
      if (level > longint'(WEIGHT_MAX)) begin
         return WEIGHT_MAX;
      end
      return WEIGHT_BITS'(level);
   endfunction

   // Counts a failure and prints only the first few.
   task automatic note_failure(input string detail);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%0t ns: mismatch: %s", $time, detail);
      end
   endtask

   // Results are compared before the new request is predicted, since no request
   // can produce its result in the cycle of its own transfer.
   always @(posedge clock) begin
      logic [INDEX_BITS-1:0] addr;
      result_type            oldest;
      result_type            fresh;

      if (reset) begin
         owed_weights.delete();
         failures        = 0;
         weights_checked = 0;
      end else begin
         // Result transfer: check against the oldest owed weight.
         if (pop && !empty) begin
            if (owed_weights.size() == 0) begin
               note_failure($sformatf("result with none owed: weight %0d frame_done %0b",
                                      rsp_weight, rsp_frame_done));
            end else begin
               oldest = owed_weights.pop_front();
               weights_checked++;
               if (rsp_weight !== oldest.weight) begin
                  note_failure($sformatf("weight expected %0d actual %0d",
                                         oldest.weight, rsp_weight));
               end
               if (rsp_frame_done !== oldest.frame_done) begin
                  note_failure($sformatf("frame_done expected %0b actual %0b",
                                         oldest.frame_done, rsp_frame_done));
               end
            end
         end

         // Request transfer: update the private store or owe a weight.
         if (push && !full) begin
            addr = pixel_bin(req_red_level, req_green_level, req_blue_level);
            case (req_type)
               REQ_ACCUM: begin
                  // A full bin holds its value instead of wrapping.
                  if (bin_count[addr] != BIN_MAX) begin
                     bin_count[addr] = bin_count[addr] + 1'b1;
                  end
               end
               REQ_PROJECT: begin
                  fresh.weight     = count_as_weight(bin_count[addr]);
                  fresh.frame_done = req_frame_end;
                  owed_weights.push_back(fresh);
               end
               REQ_WRITE: begin
                  bin_count[addr] = BIN_BITS'(req_bin_value);
               end
               default: begin
                  // The unused request code changes nothing.
               end
            endcase
         end
      end
      expected_waiting = owed_weights.size();
   end

endmodule

// File: verif/tb_color_histogram_backproject.sv
`timescale 1ns / 100ps
// Testbench top for the color histogram back-projection block: makes clock, reset,
// request and pop stimulus, and gives the verdict. Depends on chb_pkg, the block
// and chb_weight_checker, which predicts and compares the results.

module tb_color_histogram_backproject;
   import chb_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS    = 1030;
   localparam int HOT_COLORS         = 6;
   localparam int SETTLE_CYCLES      = 10;

   logic                   clock;
   logic                   reset;
   logic                   push;
   logic                   full;
   logic [1:0]             req_type;
   logic [LEVEL_BITS-1:0]  req_blue_level;
   logic [LEVEL_BITS-1:0]  req_green_level;
   logic [LEVEL_BITS-1:0]  req_red_level;
   logic [VALUE_BITS-1:0]  req_bin_value;
   logic                   req_frame_end;
   logic                   empty;
   logic                   pop;
   logic [WEIGHT_BITS-1:0] rsp_weight;
   logic                   rsp_frame_done;

   int failures;
   int expected_waiting;
   int weights_checked;
   int request_tally [4];
   bit sender_steady;
   bit receiver_steady;

   color_histogram_backproject dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_blue_level  (req_blue_level),
      .req_green_level (req_green_level),
      .req_red_level   (req_red_level),
      .req_bin_value   (req_bin_value),
      .req_frame_end   (req_frame_end),
      .empty           (empty),
      .pop             (pop),
      .rsp_weight      (rsp_weight),
      .rsp_frame_done  (rsp_frame_done)
   );

   chb_weight_checker weight_check (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_type         (req_type),
      .req_blue_level   (req_blue_level),
      .req_green_level  (req_green_level),
      .req_red_level    (req_red_level),
      .req_bin_value    (req_bin_value),
      .req_frame_end    (req_frame_end),
      .empty            (empty),
      .pop              (pop),
      .rsp_weight       (rsp_weight),
      .rsp_frame_done   (rsp_frame_done),
      .failures         (failures),
      .expected_waiting (expected_waiting),
      .weights_checked  (weights_checked)
   );

   // Free-running clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The run ends here if the block stops making progress.
   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

   // Idle length: mostly none or short, now and then long; none during steady stretches.
   function automatic int idle_cycles(input bit steady);
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // One request transfer, after an optional idle gap; push stays high afterwards.
   task automatic transfer_pixel(
      input logic [1:0]            kind,
      input logic [LEVEL_BITS-1:0] red,
      input logic [LEVEL_BITS-1:0] green,
      input logic [LEVEL_BITS-1:0] blue,
      input logic [VALUE_BITS-1:0] value,
      input logic                  frame_mark
   );
      int gap;
      gap = idle_cycles(sender_steady);
      @(negedge clock);
      if (gap > 0) begin
         push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      push            = 1'b1;
      req_type        = kind;
      req_red_level   = red;
      req_green_level = green;
      req_blue_level  = blue;
      req_bin_value   = value;
      req_frame_end   = frame_mark;
      @(posedge clock);
      while (full) @(posedge clock);
      request_tally[kind]++;
   endtask

   // Holds the sender back until every owed weight has been transferred.
   task automatic wait_for_results();
      @(negedge clock);
      push = 1'b0;
      wait (expected_waiting == 0);
   endtask

   // Result side: pop with random stalls once reset is over.
   initial begin
      int stall;
      pop = 1'b0;
      @(negedge clock);
      wait (!reset);
      forever begin
         stall = idle_cycles(receiver_steady);
         if (stall > 0) begin
            pop = 1'b0;
            repeat (stall) @(negedge clock);
         end
         pop = 1'b1;
         @(negedge clock);
      end
   end

   // Request side: reset, directed requests, then random requests.
   initial begin
      logic [LEVEL_BITS-1:0] hot_red   [HOT_COLORS];
      logic [LEVEL_BITS-1:0] hot_green [HOT_COLORS];
      logic [LEVEL_BITS-1:0] hot_blue  [HOT_COLORS];
      logic [LEVEL_BITS-1:0] low_mask;
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] green;
      logic [LEVEL_BITS-1:0] blue;
      logic [VALUE_BITS-1:0] value;
      logic [1:0]            kind;
      int                    roll;
      int                    pick;

      reset           = 1'b1;
      push            = 1'b0;
      req_type        = REQ_ACCUM;
      req_red_level   = '0;
      req_green_level = '0;
      req_blue_level  = '0;
      req_bin_value   = '0;
      req_frame_end   = 1'b0;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      foreach (request_tally[i]) begin
         request_tally[i] = 0;
      end
      low_mask = LEVEL_BITS'((1 << (LEVEL_BITS - CHANNEL_BITS)) - 1);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty bin, corner bins, full bin, ignored frame marks, unused code.
      transfer_pixel(REQ_PROJECT, 8'd0,   8'd0,   8'd0,   16'h0000, 1'b1);
      transfer_pixel(REQ_ACCUM,   8'd255, 8'd255, 8'd255, 16'hFFFF, 1'b0);
      transfer_pixel(REQ_ACCUM,   8'd252, 8'd253, 8'd254, 16'h0000, 1'b1);
      transfer_pixel(REQ_PROJECT, 8'd255, 8'd255, 8'd255, 16'h0000, 1'b0);
      transfer_pixel(REQ_WRITE,   8'd255, 8'd0,   8'd0,   16'hFFFF, 1'b1);
      transfer_pixel(REQ_ACCUM,   8'd255, 8'd0,   8'd0,   16'h0000, 1'b0);
      transfer_pixel(REQ_PROJECT, 8'd255, 8'd0,   8'd0,   16'h0000, 1'b0);
      transfer_pixel(REQ_WRITE,   8'd0,   8'd255, 8'd0,   16'hA5A5, 1'b0);
      transfer_pixel(REQ_WRITE,   8'd0,   8'd0,   8'd255, 16'h5A5A, 1'b0);
      transfer_pixel(REQ_PROJECT, 8'd0,   8'd255, 8'd0,   16'hFFFF, 1'b1);
      transfer_pixel(REQ_PROJECT, 8'd0,   8'd0,   8'd255, 16'h0000, 1'b0);
      transfer_pixel(REQ_UNUSED,  8'd0,   8'd255, 8'd0,   16'h0000, 1'b1);
      transfer_pixel(REQ_PROJECT, 8'd0,   8'd255, 8'd0,   16'h0000, 1'b1);
      transfer_pixel(REQ_ACCUM,   8'd3,   8'd3,   8'd3,   16'h0000, 1'b0);
      transfer_pixel(REQ_PROJECT, 8'd0,   8'd0,   8'd0,   16'h0000, 1'b0);
      transfer_pixel(REQ_WRITE,   8'd255, 8'd255, 8'd255, 16'h0000, 1'b0);
      transfer_pixel(REQ_PROJECT, 8'd255, 8'd255, 8'd255, 16'h0000, 1'b1);
      transfer_pixel(REQ_WRITE,   8'd128, 8'd64,  8'd32,  16'hFFFE, 1'b0);
      transfer_pixel(REQ_ACCUM,   8'd130, 8'd66,  8'd34,  16'h0000, 1'b1);
      transfer_pixel(REQ_ACCUM,   8'd129, 8'd65,  8'd33,  16'h0000, 1'b0);
      transfer_pixel(REQ_PROJECT, 8'd128, 8'd64,  8'd32,  16'h0000, 1'b0);
      wait_for_results();

      // Random: mostly a few hot bins so counts grow and saturate, some random pixels.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 200 == 0) begin
            foreach (hot_red[h]) begin
               hot_red[h]   = LEVEL_BITS'($urandom);
               hot_green[h] = LEVEL_BITS'($urandom);
               hot_blue[h]  = LEVEL_BITS'($urandom);
            end
         end
         if (n % 100 == 0) begin
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
         end
         if (n % 300 == 150) begin
            wait_for_results();
         end

         if ($urandom_range(0, 4) == 0) begin
            red   = LEVEL_BITS'($urandom);
            green = LEVEL_BITS'($urandom);
            blue  = LEVEL_BITS'($urandom);
         end else begin
            pick  = $urandom_range(0, HOT_COLORS - 1);
            red   = (hot_red[pick]   & ~low_mask) | (LEVEL_BITS'($urandom) & low_mask);
            green = (hot_green[pick] & ~low_mask) | (LEVEL_BITS'($urandom) & low_mask);
            blue  = (hot_blue[pick]  & ~low_mask) | (LEVEL_BITS'($urandom) & low_mask);
         end

         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            kind = REQ_ACCUM;
         end else if (roll < 80) begin
            kind = REQ_PROJECT;
         end else if (roll < 95) begin
            kind = REQ_WRITE;
         end else begin
            kind = REQ_UNUSED;
         end

         // Write values near the top of the range let accumulation reach saturation.
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            value = VALUE_BITS'($urandom);
         end else if (roll < 85) begin
            value = VALUE_BITS'($urandom_range(16'hFFF0, 16'hFFFF));
         end else begin
            value = VALUE_BITS'($urandom_range(0, 15));
         end

         transfer_pixel(kind, red, green, blue, value, $urandom_range(0, 3) == 0);
      end

      // Let every owed weight arrive, then allow for work still in flight.
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d accumulate, %0d back-project, %0d write and %0d unused requests,",
               request_tally[REQ_ACCUM], request_tally[REQ_PROJECT],
               request_tally[REQ_WRITE], request_tally[REQ_UNUSED]);
      $display("with %0d weights compared under random stalls on both sides.",
               weights_checked);
      if (failures == 0 && expected_waiting == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/chb_pkg.sv
hdl/chb_ram.sv
hdl/chb_front.sv
hdl/chb_back.sv
hdl/color_histogram_backproject.sv
hdl/chb_checker.sv
verif/chb_weight_checker.sv
verif/tb_color_histogram_backproject.sv
